### hw/rtl/cbf_pkg.sv
// Shared types, constants and helper functions of the Bezier flattener.
package cbf_pkg;

   localparam int COORD_W     = 32;
   localparam int MUL_W       = 70;
   localparam int PROD_W      = 2 * MUL_W;
   localparam int MAX_DEPTH   = 5;
   localparam int STACK_DEPTH = 6;
   localparam int LVL_W       = 3;
   localparam int TOP_W       = 3;
   localparam int ENTRY_W     = 8 * COORD_W + LVL_W;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [MUL_W-1:0]   mop_type;
   typedef logic signed [PROD_W-1:0]  wide_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_GO,
      ST_MUL_WAIT,
      ST_DECIDE,
      ST_ACT,
      ST_POP,
      ST_LOAD
   } state_type;

   typedef enum logic [3:0] {
      OP_CXX, OP_CYY, OP_E2A, OP_E2B, OP_E3A, OP_E3B, OP_TK, OP_SS,
      OP_D2A, OP_D2B, OP_D3A, OP_D3B, OP_T2A, OP_T2B, OP_T3A, OP_T3B
   } op_type;

   typedef enum logic [2:0] {
      ACT_NONE, ACT_P2, ACT_P3, ACT_MID, ACT_SPLIT
   } act_type;

   // a - b, sign-extended to multiplier operand width
   function automatic mop_type diff(input coord_type a, input coord_type b);
      mop_type ea;
      mop_type eb;
      ea = mop_type'(a);
      eb = mop_type'(b);
      return ea - eb;
   endfunction

   // floor((a + b) / 2)
   function automatic coord_type halve(input coord_type a, input coord_type b);
      logic signed [COORD_W:0] s;
      s = {a[COORD_W-1], a} + {b[COORD_W-1], b};
      return s[COORD_W:1];
   endfunction

endpackage

### hw/rtl/cubic_bezier_flattener_unit.sv
// Top level: adaptive cubic Bezier flattener with stack memory and shared multiplier.
// A curve is taken when start is high and busy is low; the start point appears on the
// result ports the next cycle, then the chosen vertices, then the end point with
// rsp_last_point set, each for one cycle under rsp_valid; the receiver cannot hold
// them off. Each subdivision node runs 8 to 15 multiplications on one bit-serial
// multiplier that steps through the magnitude of its second operand one bit at a time
// and stops when no set bit is left; a curve visits up to 63 nodes. Pending right
// halves live in a six-entry stack memory with a registered read port.
module cubic_bezier_flattener_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_start_x,
   input  logic [31:0] req_start_y,
   input  logic [31:0] req_ctrl1_x,
   input  logic [31:0] req_ctrl1_y,
   input  logic [31:0] req_ctrl2_x,
   input  logic [31:0] req_ctrl2_y,
   input  logic [31:0] req_end_x,
   input  logic [31:0] req_end_y,
   output logic        rsp_valid,
   output logic [31:0] rsp_point_x,
   output logic [31:0] rsp_point_y,
   output logic        rsp_last_point,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cbf_pkg::state_type state_ff, state_in;
   cbf_pkg::op_type    op_ff, op_in;
   cbf_pkg::act_type   act_ff, act_in;
   cbf_pkg::coord_type q_ff [8];
   cbf_pkg::coord_type q_in [8];
   logic [cbf_pkg::LVL_W-1:0] lvl_ff, lvl_in;
   logic [cbf_pkg::TOP_W-1:0] top_ff, top_in;
   cbf_pkg::coord_type end_x_ff, end_x_in, end_y_ff, end_y_in;
   cbf_pkg::wide_type  acc_ff, acc_in, ch_ff, ch_in, tk_ff, tk_in;
   cbf_pkg::wide_type  e2_ff, e2_in, e3_ff, e3_in, t2_ff, t2_in, s_ff, s_in;
   logic               sel2_ff, sel2_in, sel3_ff, sel3_in, need3_ff, need3_in;
   logic [31:0]        tol_ff;
   logic               rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [31:0]        rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic [cbf_pkg::ENTRY_W-1:0] stk_mem [cbf_pkg::STACK_DEPTH];
   logic [cbf_pkg::ENTRY_W-1:0] stk_rd_ff, stk_wr_data;
   logic                        stk_wr_en, stk_rd_en;
   logic [cbf_pkg::TOP_W-1:0]   stk_wr_addr, stk_rd_addr;

   logic               mul_start, mul_done;
   cbf_pkg::mop_type   mul_a, mul_b;
   cbf_pkg::wide_type  mul_p, tol_w, t3_w, abs_diff;
   cbf_pkg::mop_type   wx, wy;
   cbf_pkg::coord_type ax, ay, bx, by, cx, cy, abx, aby, bcx, bcy, mx, my;
   cbf_pkg::coord_type p2x, p2y, p3x, p3y;
   logic               in2, in3, accept, cfg_wr;

   assign accept = start && !busy;
   assign busy   = (state_ff != cbf_pkg::ST_IDLE);
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite && !paddr[2];
   assign prdata = paddr[2] ? 32'd0 : tol_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_last_point = rsp_last_ff;

   cbf_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .p     (mul_p)
   );

   // operand select per multiplication step
   always_comb begin
      wx    = cbf_pkg::diff(q_ff[6], q_ff[0]);
      wy    = cbf_pkg::diff(q_ff[7], q_ff[1]);
      tol_w = cbf_pkg::wide_type'({1'b0, tol_ff});
      p2x   = sel2_ff ? q_ff[6] : q_ff[0];
      p2y   = sel2_ff ? q_ff[7] : q_ff[1];
      p3x   = sel3_ff ? q_ff[6] : q_ff[0];
      p3y   = sel3_ff ? q_ff[7] : q_ff[1];
      unique case (op_ff)
         cbf_pkg::OP_CXX: begin mul_a = wx; mul_b = wx; end
         cbf_pkg::OP_CYY: begin mul_a = wy; mul_b = wy; end
         cbf_pkg::OP_E2A: begin mul_a = cbf_pkg::diff(q_ff[2], q_ff[6]); mul_b = wy; end
         cbf_pkg::OP_E2B: begin mul_a = cbf_pkg::diff(q_ff[3], q_ff[7]); mul_b = wx; end
         cbf_pkg::OP_E3A: begin mul_a = cbf_pkg::diff(q_ff[4], q_ff[6]); mul_b = wy; end
         cbf_pkg::OP_E3B: begin mul_a = cbf_pkg::diff(q_ff[5], q_ff[7]); mul_b = wx; end
         cbf_pkg::OP_TK: begin
            mul_a = cbf_pkg::mop_type'(tol_w);
            mul_b = ch_ff[cbf_pkg::MUL_W-1:0];
         end
         cbf_pkg::OP_SS: begin
            mul_a = s_ff[cbf_pkg::MUL_W-1:0];
            mul_b = s_ff[cbf_pkg::MUL_W-1:0];
         end
         cbf_pkg::OP_D2A: begin
            mul_a = cbf_pkg::diff(q_ff[2], p2x); mul_b = mul_a;
         end
         cbf_pkg::OP_D2B: begin
            mul_a = cbf_pkg::diff(q_ff[3], p2y); mul_b = mul_a;
         end
         cbf_pkg::OP_D3A: begin
            mul_a = cbf_pkg::diff(q_ff[4], p3x); mul_b = mul_a;
         end
         cbf_pkg::OP_D3B: begin
            mul_a = cbf_pkg::diff(q_ff[5], p3y); mul_b = mul_a;
         end
         cbf_pkg::OP_T2A: begin mul_a = cbf_pkg::diff(q_ff[2], q_ff[0]); mul_b = wx; end
         cbf_pkg::OP_T2B: begin mul_a = cbf_pkg::diff(q_ff[3], q_ff[1]); mul_b = wy; end
         cbf_pkg::OP_T3A: begin mul_a = cbf_pkg::diff(q_ff[4], q_ff[0]); mul_b = wx; end
         cbf_pkg::OP_T3B: begin mul_a = cbf_pkg::diff(q_ff[5], q_ff[1]); mul_b = wy; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // split point arithmetic
   always_comb begin
      ax  = cbf_pkg::halve(q_ff[0], q_ff[2]);
      ay  = cbf_pkg::halve(q_ff[1], q_ff[3]);
      bx  = cbf_pkg::halve(q_ff[2], q_ff[4]);
      by  = cbf_pkg::halve(q_ff[3], q_ff[5]);
      cx  = cbf_pkg::halve(q_ff[4], q_ff[6]);
      cy  = cbf_pkg::halve(q_ff[5], q_ff[7]);
      abx = cbf_pkg::halve(ax, bx);
      aby = cbf_pkg::halve(ay, by);
      bcx = cbf_pkg::halve(bx, cx);
      bcy = cbf_pkg::halve(by, cy);
      mx  = cbf_pkg::halve(abx, bcx);
      my  = cbf_pkg::halve(aby, bcy);
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      act_in       = act_ff;
      q_in         = q_ff;
      lvl_in       = lvl_ff;
      top_in       = top_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      acc_in       = acc_ff;
      ch_in        = ch_ff;
      tk_in        = tk_ff;
      e2_in        = e2_ff;
      e3_in        = e3_ff;
      t2_in        = t2_ff;
      s_in         = s_ff;
      sel2_in      = sel2_ff;
      sel3_in      = sel3_ff;
      need3_in     = need3_ff;
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      mul_start    = 1'b0;
      stk_wr_en    = 1'b0;
      stk_rd_en    = 1'b0;
      stk_wr_addr  = top_ff;
      stk_rd_addr  = top_ff - 1'b1;
      stk_wr_data  = {lvl_ff + 1'b1, q_ff[7], q_ff[6], cy, cx, bcy, bcx, my, mx};
      abs_diff     = acc_ff - mul_p;
      t3_w         = acc_ff + mul_p;
      in2          = (t2_ff > 0) && (t2_ff < ch_ff);
      in3          = (t3_w > 0) && (t3_w < ch_ff);
      unique case (state_ff)
         cbf_pkg::ST_IDLE: begin
            if (start) begin
               q_in[0]      = req_start_x;
               q_in[1]      = req_start_y;
               q_in[2]      = req_ctrl1_x;
               q_in[3]      = req_ctrl1_y;
               q_in[4]      = req_ctrl2_x;
               q_in[5]      = req_ctrl2_y;
               q_in[6]      = req_end_x;
               q_in[7]      = req_end_y;
               end_x_in     = req_end_x;
               end_y_in     = req_end_y;
               lvl_in       = '0;
               top_in       = '0;
               rsp_valid_in = 1'b1;
               rsp_x_in     = req_start_x;
               rsp_y_in     = req_start_y;
               op_in        = cbf_pkg::OP_CXX;
               state_in     = cbf_pkg::ST_MUL_GO;
            end
         end
         cbf_pkg::ST_MUL_GO: begin
            mul_start = 1'b1;
            state_in  = cbf_pkg::ST_MUL_WAIT;
         end
         cbf_pkg::ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = cbf_pkg::ST_MUL_GO;
               case (op_ff)
                  cbf_pkg::OP_CXX: begin acc_in = mul_p; op_in = cbf_pkg::OP_CYY; end
                  cbf_pkg::OP_CYY: begin
                     ch_in = acc_ff + mul_p; op_in = cbf_pkg::OP_E2A;
                  end
                  cbf_pkg::OP_E2A: begin acc_in = mul_p; op_in = cbf_pkg::OP_E2B; end
                  cbf_pkg::OP_E2B: begin
                     e2_in = abs_diff[cbf_pkg::PROD_W-1] ? -abs_diff : abs_diff;
                     op_in = cbf_pkg::OP_E3A;
                  end
                  cbf_pkg::OP_E3A: begin acc_in = mul_p; op_in = cbf_pkg::OP_E3B; end
                  cbf_pkg::OP_E3B: begin
                     e3_in = abs_diff[cbf_pkg::PROD_W-1] ? -abs_diff : abs_diff;
                     op_in = cbf_pkg::OP_TK;
                  end
                  cbf_pkg::OP_TK: begin
                     tk_in = mul_p;
                     if (e2_ff != 0 || e3_ff != 0) begin
                        // a zero cross product adds nothing to the sum
                        s_in  = e2_ff + e3_ff;
                        op_in = cbf_pkg::OP_SS;
                     end else if (ch_ff == 0) begin
                        sel2_in  = 1'b0;
                        sel3_in  = 1'b1;
                        need3_in = 1'b1;
                        op_in    = cbf_pkg::OP_D2A;
                     end else begin
                        op_in = cbf_pkg::OP_T2A;
                     end
                  end
                  cbf_pkg::OP_SS: begin
                     act_in   = (mul_p <= tk_ff) ? cbf_pkg::ACT_MID : cbf_pkg::ACT_SPLIT;
                     state_in = cbf_pkg::ST_ACT;
                  end
                  cbf_pkg::OP_T2A: begin acc_in = mul_p; op_in = cbf_pkg::OP_T2B; end
                  cbf_pkg::OP_T2B: begin
                     t2_in = acc_ff + mul_p; op_in = cbf_pkg::OP_T3A;
                  end
                  cbf_pkg::OP_T3A: begin acc_in = mul_p; op_in = cbf_pkg::OP_T3B; end
                  cbf_pkg::OP_T3B: begin
                     sel2_in  = (t2_ff > 0);
                     sel3_in  = (t3_w > 0);
                     need3_in = !in3;
                     if (in2 && in3) begin
                        act_in   = cbf_pkg::ACT_NONE;
                        state_in = cbf_pkg::ST_ACT;
                     end else if (!in2) begin
                        op_in = cbf_pkg::OP_D2A;
                     end else begin
                        e2_in = '0;
                        op_in = cbf_pkg::OP_D3A;
                     end
                  end
                  cbf_pkg::OP_D2A: begin acc_in = mul_p; op_in = cbf_pkg::OP_D2B; end
                  cbf_pkg::OP_D2B: begin
                     e2_in = acc_ff + mul_p;
                     if (need3_ff) begin
                        op_in = cbf_pkg::OP_D3A;
                     end else begin
                        e3_in    = '0;
                        state_in = cbf_pkg::ST_DECIDE;
                     end
                  end
                  cbf_pkg::OP_D3A: begin acc_in = mul_p; op_in = cbf_pkg::OP_D3B; end
                  cbf_pkg::OP_D3B: begin
                     e3_in    = acc_ff + mul_p;
                     state_in = cbf_pkg::ST_DECIDE;
                  end
                  default: state_in = cbf_pkg::ST_IDLE;
               endcase
            end
         end
         cbf_pkg::ST_DECIDE: begin
            if (e2_ff > e3_ff) begin
               act_in = (e2_ff < tol_w) ? cbf_pkg::ACT_P2 : cbf_pkg::ACT_SPLIT;
            end else begin
               act_in = (e3_ff < tol_w) ? cbf_pkg::ACT_P3 : cbf_pkg::ACT_SPLIT;
            end
            state_in = cbf_pkg::ST_ACT;
         end
         cbf_pkg::ST_ACT: begin
            state_in = cbf_pkg::ST_POP;
            case (act_ff)
               cbf_pkg::ACT_P2: begin
                  rsp_valid_in = 1'b1; rsp_x_in = q_ff[2]; rsp_y_in = q_ff[3];
               end
               cbf_pkg::ACT_P3: begin
                  rsp_valid_in = 1'b1; rsp_x_in = q_ff[4]; rsp_y_in = q_ff[5];
               end
               cbf_pkg::ACT_MID: begin
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = bx;
                  rsp_y_in     = by;
               end
               cbf_pkg::ACT_SPLIT: begin
                  if (lvl_ff < cbf_pkg::LVL_W'(cbf_pkg::MAX_DEPTH) &&
                      top_ff < cbf_pkg::TOP_W'(cbf_pkg::STACK_DEPTH)) begin
                     // push the right half, descend into the left half
                     stk_wr_en = 1'b1;
                     top_in    = top_ff + 1'b1;
                     lvl_in    = lvl_ff + 1'b1;
                     q_in[2]   = ax;
                     q_in[3]   = ay;
                     q_in[4]   = abx;
                     q_in[5]   = aby;
                     q_in[6]   = mx;
                     q_in[7]   = my;
                     op_in     = cbf_pkg::OP_CXX;
                     state_in  = cbf_pkg::ST_MUL_GO;
                  end
               end
               default: ;
            endcase
         end
         cbf_pkg::ST_POP: begin
            if (top_ff == '0) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_x_in     = end_x_ff;
               rsp_y_in     = end_y_ff;
               state_in     = cbf_pkg::ST_IDLE;
            end else begin
               stk_rd_en = 1'b1;
               top_in    = top_ff - 1'b1;
               state_in  = cbf_pkg::ST_LOAD;
            end
         end
         cbf_pkg::ST_LOAD: begin
            for (int i = 0; i < 8; i++) begin
               q_in[i] = stk_rd_ff[i*cbf_pkg::COORD_W +: cbf_pkg::COORD_W];
            end
            lvl_in   = stk_rd_ff[cbf_pkg::ENTRY_W-1 -: cbf_pkg::LVL_W];
            op_in    = cbf_pkg::OP_CXX;
            state_in = cbf_pkg::ST_MUL_GO;
         end
         default: state_in = cbf_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (stk_wr_en) stk_mem[stk_wr_addr] <= stk_wr_data;
      if (stk_rd_en) stk_rd_ff <= stk_mem[stk_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cbf_pkg::ST_IDLE;
         top_ff       <= '0;
         tol_ff       <= 32'd16384;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         top_ff       <= top_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
         if (cfg_wr) tol_ff <= pwdata;
      end
      op_ff    <= op_in;
      act_ff   <= act_in;
      q_ff     <= q_in;
      lvl_ff   <= lvl_in;
      end_x_ff <= end_x_in;
      end_y_ff <= end_y_in;
      acc_ff   <= acc_in;
      ch_ff    <= ch_in;
      tk_ff    <= tk_in;
      e2_ff    <= e2_in;
      e3_ff    <= e3_in;
      t2_ff    <= t2_in;
      s_ff     <= s_in;
      sel2_ff  <= sel2_in;
      sel3_ff  <= sel3_in;
      need3_ff <= need3_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_point |-> !busy)
      else $error("last word shown while a curve is still running");

   a_start_word: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid && !rsp_last_point)
      else $error("start point word missing after accept");

   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      top_ff <= cbf_pkg::TOP_W'(cbf_pkg::STACK_DEPTH))
      else $error("stack overflow");

endmodule

### hw/rtl/cbf_mul.sv
// Bit-serial signed multiplier, one partial product per cycle.
module cbf_mul (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  cbf_pkg::mop_type  a,
   input  cbf_pkg::mop_type  b,
   output logic              done,
   output cbf_pkg::wide_type p
);

   logic                              busy_ff, busy_in;
   logic                              neg_ff, neg_in;
   logic [cbf_pkg::PROD_W-1:0]        ma_ff, ma_in;
   logic [cbf_pkg::MUL_W-1:0]         mb_ff, mb_in;
   logic [cbf_pkg::PROD_W-1:0]        acc_ff, acc_in;
   logic [cbf_pkg::MUL_W-1:0]         abs_a, abs_b;

   always_comb begin
      abs_a   = a[cbf_pkg::MUL_W-1] ? -a : a;
      abs_b   = b[cbf_pkg::MUL_W-1] ? -b : b;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      acc_in  = acc_ff;
      done    = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = a[cbf_pkg::MUL_W-1] ^ b[cbf_pkg::MUL_W-1];
         ma_in   = {{cbf_pkg::MUL_W{1'b0}}, abs_a};
         mb_in   = abs_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         if (mb_ff == '0) begin
            done    = 1'b1;
            busy_in = 1'b0;
         end else begin
            if (mb_ff[0]) acc_in = acc_ff + ma_ff;
            ma_in = ma_ff << 1;
            mb_in = mb_ff >> 1;
         end
      end
      p = neg_ff ? -cbf_pkg::wide_type'(acc_ff) : cbf_pkg::wide_type'(acc_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      neg_ff <= neg_in;
      ma_ff  <= ma_in;
      mb_ff  <= mb_in;
      acc_ff <= acc_in;
   end

endmodule
